FILE: design/loop_note_event_table_top_defines.svh
// Assertion macros for the loop note event table.
// Used by the top level only; expects clock and reset in scope.
`ifndef LOOP_NOTE_EVENT_TABLE_TOP_DEFINES_SVH
`define LOOP_NOTE_EVENT_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define LNET_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LNET_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/lnet_pkg.sv
// Shared constants and types for the loop note event table.
// No dependencies.
package lnet_pkg;

   localparam int MAX_EVENTS = 16;
   localparam int IDX_W      = $clog2(MAX_EVENTS);
   localparam int CNT_W      = $clog2(MAX_EVENTS + 1);

   localparam logic [15:0] END_PAD = 16'd4;

   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_ON   = 2'd1;
   localparam logic [1:0] ACT_OFF  = 2'd2;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_PUT0,
      OP_DROP,
      OP_INSERT,
      OP_ERASE,
      OP_REPLACE,
      OP_NEXT,
      OP_TRUNC_NEXT,
      OP_TRUNC_APPEND,
      OP_APPEND,
      OP_TICK,
      OP_EMIT
   } op_type;

   typedef struct packed {
      logic is_tick;
      logic empty;
      logic full;
      logic s_lt_start;
      logic e_lt_start;
      logic s_gt_end;
      logic last;
      logic play_ok;
   } stat_type;

endpackage

FILE: design/lnet_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on nothing.
interface lnet_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [15:0] time_pos;
   logic [2:0]  note;
   logic [15:0] end_pos;

   modport source (output valid, func, time_pos, note, end_pos, input ready);
   modport sink (input valid, func, time_pos, note, end_pos, output ready);
endinterface

interface lnet_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [2:0] note_out;
   logic       status;
   logic [4:0] event_count;

   modport source (output valid, action, note_out, status, event_count, input ready);
   modport sink (input valid, action, note_out, status, event_count, output ready);
endinterface

FILE: design/loop_note_event_table_top.sv
// Loop note event table: sorted table of note events with a play pointer.
// Request channel (req_chan): func 0 adds an event (time_pos, note, end_pos),
// func 1 is a loop position tick at time_pos. Response channel (rsp_chan):
// one word per request with action (none, note on, note off), note_out,
// status (add dropped on a full table) and event_count after the request.
// Requests are taken one at a time: ready is high only while idle.
// A tick or a dropped add is settled in the first walk step; an add walks
// the table one entry per cycle until it places the new event, and then
// the response is emitted.
// The response sits in an output register; a new request is accepted while
// it waits, and the next response is held back until the receiver takes the
// previous word. While that next word is held, no further request is taken.
// Reset (synchronous, active high) empties the table, disarms all entries,
// zeroes the play pointer and drops any pending response.
// Depends on lnet_pkg, lnet_if, lnet_ctrl, lnet_dpath and the defines header.
`include "loop_note_event_table_top_defines.svh"

module loop_note_event_table_top (
   input logic       clock,
   input logic       reset,
   lnet_req_if.sink  req_chan,
   lnet_rsp_if.source rsp_chan
);

   lnet_pkg::op_type   op;
   lnet_pkg::stat_type st;
   logic               drop_seen, act_seen, at_full;

   lnet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .st        (st),
      .op        (op)
   );

   lnet_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .in_func    (req_chan.func),
      .in_time    (req_chan.time_pos),
      .in_note    (req_chan.note),
      .in_end     (req_chan.end_pos),
      .st         (st),
      .out_action (rsp_chan.action),
      .out_note   (rsp_chan.note_out),
      .out_status (rsp_chan.status),
      .out_count  (rsp_chan.event_count)
   );

   assign drop_seen = rsp_chan.valid && rsp_chan.status;
   assign act_seen  = rsp_chan.valid && (rsp_chan.action != lnet_pkg::ACT_NONE);
   assign at_full   = (rsp_chan.event_count == 5'(lnet_pkg::MAX_EVENTS));

   `LNET_ASSERT_NOW(a_drop_full, drop_seen, at_full, "dropped add but table not full")
   `LNET_ASSERT_NOW(a_act_ok, act_seen, !rsp_chan.status, "note action with drop status")
   `LNET_ASSERT_NOW(a_play_ok, 1'b1, st.play_ok, "play pointer beyond held entries")
   `LNET_ASSERT_NEXT(a_busy, req_chan.valid && req_chan.ready, !req_chan.ready, "taken while busy")

endmodule

FILE: design/lnet_dpath.sv
// Datapath: event table registers, walk pointer, play pointer, result word.
// Depends on lnet_pkg.
module lnet_dpath (
   input  logic               clock,
   input  logic               reset,
   input  lnet_pkg::op_type   op,
   input  logic               in_func,
   input  logic [15:0]        in_time,
   input  logic [2:0]         in_note,
   input  logic [15:0]        in_end,
   output lnet_pkg::stat_type st,
   output logic [1:0]         out_action,
   output logic [2:0]         out_note,
   output logic               out_status,
   output logic [4:0]         out_count
);

   logic [15:0] start_ff [lnet_pkg::MAX_EVENTS];
   logic [15:0] start_in [lnet_pkg::MAX_EVENTS];
   logic [15:0] end_ff   [lnet_pkg::MAX_EVENTS];
   logic [15:0] end_in   [lnet_pkg::MAX_EVENTS];
   logic [2:0]  note_ff  [lnet_pkg::MAX_EVENTS];
   logic [2:0]  note_in  [lnet_pkg::MAX_EVENTS];
   logic [lnet_pkg::MAX_EVENTS-1:0] armed_ff, armed_in;

   logic [lnet_pkg::CNT_W-1:0] count_ff, count_in;
   logic [lnet_pkg::IDX_W-1:0] play_ff, play_in;
   logic [lnet_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [15:0] s_ff, s_in, e_ff, e_in;
   logic [2:0]  n_ff, n_in;
   logic        tick_ff, tick_in;
   logic [1:0]  act_ff, act_in;
   logic [2:0]  nout_ff, nout_in;
   logic        stat_ff, stat_in;
   logic [1:0]  ract_ff, ract_in;
   logic [2:0]  rnote_ff, rnote_in;
   logic        rstat_ff, rstat_in;
   logic [4:0]  rcount_ff, rcount_in;

   logic [lnet_pkg::IDX_W-1:0] rd_idx, ins_pos, idx_nx;
   logic [lnet_pkg::CNT_W-1:0] idx_ext, play_ext;
   logic [15:0] rd_start, rd_end;
   logic [2:0]  rd_note;
   logic        rd_armed, do_ins;

   // one read address: the play pointer for ticks, the walk pointer for adds
   assign rd_idx   = tick_ff ? play_ff : idx_ff;
   assign rd_start = start_ff[rd_idx];
   assign rd_end   = end_ff[rd_idx];
   assign rd_note  = note_ff[rd_idx];
   assign rd_armed = armed_ff[rd_idx];
   assign idx_nx   = idx_ff + 1'b1;
   assign idx_ext  = lnet_pkg::CNT_W'(idx_ff) + 1'b1;
   assign play_ext = lnet_pkg::CNT_W'(play_ff) + 1'b1;

   always_comb begin
      st.is_tick    = tick_ff;
      st.empty      = (count_ff == '0);
      st.full       = (count_ff == lnet_pkg::CNT_W'(lnet_pkg::MAX_EVENTS));
      st.s_lt_start = (s_ff < rd_start);
      st.e_lt_start = (e_ff < rd_start);
      st.s_gt_end   = (s_ff > rd_end);
      st.last       = (idx_ext == count_ff);
      st.play_ok    = (count_ff == '0) || (lnet_pkg::CNT_W'(play_ff) < count_ff);
   end

   always_comb begin
      start_in  = start_ff;
      end_in    = end_ff;
      note_in   = note_ff;
      armed_in  = armed_ff;
      count_in  = count_ff;
      play_in   = play_ff;
      idx_in    = idx_ff;
      s_in      = s_ff;
      e_in      = e_ff;
      n_in      = n_ff;
      tick_in   = tick_ff;
      act_in    = act_ff;
      nout_in   = nout_ff;
      stat_in   = stat_ff;
      ract_in   = ract_ff;
      rnote_in  = rnote_ff;
      rstat_in  = rstat_ff;
      rcount_in = rcount_ff;
      do_ins    = 1'b0;
      ins_pos   = idx_ff;

      unique case (op)
         lnet_pkg::OP_LOAD: begin
            s_in    = in_time;
            e_in    = (in_end == in_time) ? in_time + lnet_pkg::END_PAD : in_end;
            n_in    = in_note;
            tick_in = in_func;
            idx_in  = '0;
            act_in  = lnet_pkg::ACT_NONE;
            nout_in = '0;
            stat_in = 1'b0;
         end
         lnet_pkg::OP_PUT0: begin
            do_ins  = 1'b1;
            ins_pos = '0;
            play_in = '0;
         end
         lnet_pkg::OP_DROP: stat_in = 1'b1;
         lnet_pkg::OP_INSERT: do_ins = 1'b1;
         lnet_pkg::OP_ERASE: begin
            for (int k = 0; k < lnet_pkg::MAX_EVENTS - 1; k++) begin
               if (lnet_pkg::IDX_W'(k) >= idx_ff
                   && lnet_pkg::CNT_W'(k) + 1'b1 < count_ff) begin
                  start_in[k] = start_ff[k+1];
                  end_in[k]   = end_ff[k+1];
                  note_in[k]  = note_ff[k+1];
                  armed_in[k] = armed_ff[k+1];
               end
            end
            count_in = count_ff - 1'b1;
            // pointer moved past the removed entry, then slides back onto it
            play_in  = idx_ff;
         end
         lnet_pkg::OP_REPLACE: begin
            start_in[idx_ff] = s_ff;
            end_in[idx_ff]   = e_ff;
            note_in[idx_ff]  = n_ff;
            armed_in[idx_ff] = 1'b0;
            play_in          = '0;
         end
         lnet_pkg::OP_NEXT: idx_in = idx_nx;
         lnet_pkg::OP_TRUNC_NEXT: begin
            end_in[idx_ff] = s_ff - 1'b1;
            idx_in         = idx_nx;
         end
         lnet_pkg::OP_TRUNC_APPEND: begin
            end_in[idx_ff] = s_ff - 1'b1;
            play_in        = '0;
            do_ins         = 1'b1;
            ins_pos        = idx_nx;
         end
         lnet_pkg::OP_APPEND: begin
            do_ins  = 1'b1;
            ins_pos = idx_nx;
         end
         lnet_pkg::OP_TICK: begin
            if (count_ff != '0) begin
               if (!rd_armed) begin
                  if (s_ff == rd_start) begin
                     armed_in[rd_idx] = 1'b1;
                     act_in           = lnet_pkg::ACT_ON;
                     nout_in          = rd_note;
                  end
               end else if (s_ff == rd_end) begin
                  armed_in[rd_idx] = 1'b0;
                  act_in           = lnet_pkg::ACT_OFF;
                  nout_in          = rd_note;
                  play_in          = (play_ext < count_ff) ? play_ff + 1'b1 : '0;
               end
            end
         end
         lnet_pkg::OP_EMIT: begin
            ract_in   = act_ff;
            rnote_in  = nout_ff;
            rstat_in  = stat_ff;
            rcount_in = 5'(count_ff);
         end
         default: ;
      endcase

      if (do_ins) begin
         for (int k = 1; k < lnet_pkg::MAX_EVENTS; k++) begin
            if (lnet_pkg::IDX_W'(k) > ins_pos && lnet_pkg::CNT_W'(k) <= count_ff) begin
               start_in[k] = start_ff[k-1];
               end_in[k]   = end_ff[k-1];
               note_in[k]  = note_ff[k-1];
               armed_in[k] = armed_ff[k-1];
            end
         end
         start_in[ins_pos] = s_ff;
         end_in[ins_pos]   = e_ff;
         note_in[ins_pos]  = n_ff;
         armed_in[ins_pos] = 1'b0;
         if (count_ff != '0 && play_in >= ins_pos)
            play_in = play_in + 1'b1;
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      start_ff  <= start_in;
      end_ff    <= end_in;
      note_ff   <= note_in;
      idx_ff    <= idx_in;
      s_ff      <= s_in;
      e_ff      <= e_in;
      n_ff      <= n_in;
      act_ff    <= act_in;
      nout_ff   <= nout_in;
      stat_ff   <= stat_in;
      ract_ff   <= ract_in;
      rnote_ff  <= rnote_in;
      rstat_ff  <= rstat_in;
      rcount_ff <= rcount_in;
      if (reset) begin
         armed_ff <= '0;
         count_ff <= '0;
         play_ff  <= '0;
         tick_ff  <= 1'b0;
      end else begin
         armed_ff <= armed_in;
         count_ff <= count_in;
         play_ff  <= play_in;
         tick_ff  <= tick_in;
      end
   end

   assign out_action = ract_ff;
   assign out_note   = rnote_ff;
   assign out_status = rstat_ff;
   assign out_count  = rcount_ff;

endmodule

FILE: design/lnet_ctrl.sv
// Controller: sequences one word at a time through load, table walk and emit.
// Depends on lnet_pkg.
module lnet_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  lnet_pkg::stat_type st,
   output lnet_pkg::op_type   op
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      op           = lnet_pkg::OP_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op       = lnet_pkg::OP_LOAD;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            state_in = ST_EMIT;
            priority if (st.is_tick)   op = lnet_pkg::OP_TICK;
            else if (st.full)          op = lnet_pkg::OP_DROP;
            else if (st.empty)         op = lnet_pkg::OP_PUT0;
            else if (st.s_lt_start) begin
               priority if (st.e_lt_start) op = lnet_pkg::OP_INSERT;
               else if (!st.last) begin
                  op       = lnet_pkg::OP_ERASE;
                  state_in = ST_WALK;
               end else                    op = lnet_pkg::OP_REPLACE;
            end else if (st.s_gt_end) begin
               if (!st.last) begin
                  op       = lnet_pkg::OP_NEXT;
                  state_in = ST_WALK;
               end else begin
                  op = lnet_pkg::OP_APPEND;
               end
            end else begin
               if (!st.last) begin
                  op       = lnet_pkg::OP_TRUNC_NEXT;
                  state_in = ST_WALK;
               end else begin
                  op = lnet_pkg::OP_TRUNC_APPEND;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               op           = lnet_pkg::OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
